@@ design/rqt_pkg.sv @@
package rqt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int ID_W      = 16;
   localparam int SIZE_W    = 16;
   localparam int STAMP_W   = 32;
   localparam int BYTES_W   = 22;
   localparam int PEND_W    = 21;
   localparam int COUNT_W   = 6;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [ID_W-1:0]    msg_id;
      logic [SIZE_W-1:0]  msg_bytes;
      logic [STAMP_W-1:0] sent_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SIZE_W-1:0]  removed_bytes;
      logic [STAMP_W-1:0] oldest_time;
      logic [PEND_W-1:0]  pending_bytes;
      logic [COUNT_W-1:0] pending_count;
   } rsp_type;

   // one table entry as held in a cell
   typedef struct packed {
      logic [ID_W-1:0]    ident;
      logic [SIZE_W-1:0]  size;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // where a cell takes its next value from
   typedef enum logic [1:0] {
      SRC_NBR,
      SRC_HEAD,
      SRC_INS
   } src_type;

   typedef struct packed {
      logic    load;
      src_type src;
   } cell_ctrl_type;

   // controls from the sequencer to the row of cells
   typedef struct packed {
      logic             step;
      logic             place_en;
      logic [IDX_W-1:0] place_index;
      logic             ins_en;
      logic [IDX_W-1:0] ins_index;
   } chain_ctrl_type;

endpackage

@@ design/retransmit_queue_table_top.sv @@
// Retransmission queue table: ordered list of unacknowledged messages held in
// a row of cells, entry 0 at the head, with a running byte total.
// Input channel req_*: one transfer carries an action (insert, remove by id,
// query oldest send time) and its operands. Result channel rsp_*: exactly one
// transfer per accepted item, in order.
// Insert, unknown action, and remove or query on an empty table skip the walk
// and go straight to the finishing state. Remove and query walk the entries
// held when the item arrives through the cell row, one entry per cycle. A new
// item is taken once the previous one has reached the output register.
// The output register holds a finished result while rsp_stall is high and the
// block meanwhile accepts the next item; it only waits to finish that next
// item until the register is free.
// Reset clears the entry count, byte total and output valid; entry contents
// are left as they are and only entries below the count are ever read.
module retransmit_queue_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rqt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rqt_pkg::rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      FINISH
   } state_type;

   state_type                            state_ff;
   logic [rqt_pkg::CNT_W-1:0]            count_ff;
   logic [rqt_pkg::BYTES_W-1:0]          bytes_ff;
   logic [1:0]                           action_ff;
   logic [rqt_pkg::ID_W-1:0]             id_ff;
   logic [rqt_pkg::IDX_W-1:0]            rem_ff;
   logic [rqt_pkg::CNT_W-1:0]            keep_ff;
   logic                                 first_ff;
   logic                                 found_ff;
   logic [rqt_pkg::SIZE_W-1:0]           removed_ff;
   logic [rqt_pkg::STAMP_W-1:0]          oldest_ff;
   logic [1:0]                           status_ff;
   logic                                 rsp_valid_ff;
   rqt_pkg::rsp_type                     rsp_ff;

   logic                                 req_accept;
   logic                                 full;
   logic                                 drop;
   logic                                 later;
   logic [rqt_pkg::STAMP_W-1:0]          stamp_diff;
   logic                                 out_free;
   rqt_pkg::chain_ctrl_type              chain_ctrl;
   rqt_pkg::entry_type                   ins_entry;
   rqt_pkg::entry_type                   head_entry;

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == rqt_pkg::CNT_W'(rqt_pkg::TABLE_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // head entry matches the id being removed
   assign drop = (action_ff == rqt_pkg::ACT_REMOVE) && (head_entry.ident == id_ff);

   // wrap-aware compare: head is earlier when (oldest - head) is strictly positive
   assign stamp_diff = oldest_ff - head_entry.stamp;
   assign later      = (stamp_diff != '0) && !stamp_diff[rqt_pkg::STAMP_W-1];

   // cell row control
   assign ins_entry.ident = req_payload.msg_id;
   assign ins_entry.size  = req_payload.msg_bytes;
   assign ins_entry.stamp = req_payload.sent_time;

   always_comb begin
      chain_ctrl.step        = (state_ff == WALK);
      chain_ctrl.place_en    = (state_ff == WALK) && !drop;
      chain_ctrl.place_index = rqt_pkg::IDX_W'(keep_ff + rqt_pkg::CNT_W'(rem_ff));
      chain_ctrl.ins_en      = req_accept && (req_payload.action == rqt_pkg::ACT_INSERT)
                               && !full;
      chain_ctrl.ins_index   = rqt_pkg::IDX_W'(count_ff);
   end

   rqt_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .ins_entry  (ins_entry),
      .head_entry (head_entry)
   );

   // sequencer, table totals and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result leaves unless the next one is loaded in its place
         if (rsp_valid_ff && !rsp_stall && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  action_ff  <= req_payload.action;
                  id_ff      <= req_payload.msg_id;
                  removed_ff <= '0;
                  oldest_ff  <= '0;
                  found_ff   <= 1'b0;
                  keep_ff    <= '0;
                  first_ff   <= 1'b1;
                  rem_ff     <= rqt_pkg::IDX_W'(count_ff - rqt_pkg::CNT_W'(1));
                  case (req_payload.action)
                     rqt_pkg::ACT_INSERT: begin
                        if (full) begin
                           status_ff <= rqt_pkg::ST_FULL;
                        end else begin
                           status_ff <= rqt_pkg::ST_OK;
                           count_ff  <= count_ff + rqt_pkg::CNT_W'(1);
                           bytes_ff  <= bytes_ff
                                        + rqt_pkg::BYTES_W'(req_payload.msg_bytes);
                        end
                        state_ff <= FINISH;
                     end
                     rqt_pkg::ACT_REMOVE: begin
                        if (count_ff == '0) begin
                           status_ff <= rqt_pkg::ST_NOT_FOUND;
                           state_ff  <= FINISH;
                        end else begin
                           state_ff <= WALK;
                        end
                     end
                     rqt_pkg::ACT_QUERY: begin
                        if (count_ff == '0) begin
                           status_ff <= rqt_pkg::ST_EMPTY;
                           state_ff  <= FINISH;
                        end else begin
                           state_ff <= WALK;
                        end
                     end
                     default: begin
                        status_ff <= rqt_pkg::ST_OK;
                        state_ff  <= FINISH;
                     end
                  endcase
               end
            end
            WALK: begin
               first_ff <= 1'b0;
               if (drop) begin
                  bytes_ff   <= bytes_ff - rqt_pkg::BYTES_W'(head_entry.size);
                  removed_ff <= head_entry.size;
                  found_ff   <= 1'b1;
               end else begin
                  keep_ff <= keep_ff + rqt_pkg::CNT_W'(1);
               end
               if ((action_ff == rqt_pkg::ACT_QUERY) && (first_ff || later)) begin
                  oldest_ff <= head_entry.stamp;
               end
               if (rem_ff == '0) begin
                  state_ff <= FINISH;
                  if (action_ff == rqt_pkg::ACT_REMOVE) begin
                     count_ff  <= drop ? keep_ff : keep_ff + rqt_pkg::CNT_W'(1);
                     status_ff <= (found_ff || drop) ? rqt_pkg::ST_OK
                                                     : rqt_pkg::ST_NOT_FOUND;
                  end else begin
                     status_ff <= rqt_pkg::ST_OK;
                  end
               end else begin
                  rem_ff <= rem_ff - rqt_pkg::IDX_W'(1);
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.status        <= status_ff;
                  rsp_ff.removed_bytes <= removed_ff;
                  rsp_ff.oldest_time   <= oldest_ff;
                  rsp_ff.pending_bytes <= bytes_ff[rqt_pkg::PEND_W-1:0];
                  rsp_ff.pending_count <= rqt_pkg::COUNT_W'(count_ff);
                  state_ff             <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/rqt_cell.sv @@
module rqt_cell (
   input  logic                  clock,
   input  rqt_pkg::cell_ctrl_type ctrl,
   input  rqt_pkg::entry_type    nbr_entry,
   input  rqt_pkg::entry_type    head_entry,
   input  rqt_pkg::entry_type    ins_entry,
   output rqt_pkg::entry_type    cell_entry
);

   rqt_pkg::entry_type entry_ff;
   rqt_pkg::entry_type entry_in;

   // source select
   always_comb begin
      case (ctrl.src)
         rqt_pkg::SRC_NBR:  entry_in = nbr_entry;
         rqt_pkg::SRC_HEAD: entry_in = head_entry;
         rqt_pkg::SRC_INS:  entry_in = ins_entry;
         default:           entry_in = entry_ff;
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= entry_in;
      end
   end

   assign cell_entry = entry_ff;

endmodule

@@ design/rqt_chain.sv @@
module rqt_chain (
   input  logic                    clock,
   input  rqt_pkg::chain_ctrl_type ctrl,
   input  rqt_pkg::entry_type      ins_entry,
   output rqt_pkg::entry_type      head_entry
);

   rqt_pkg::entry_type     cells [rqt_pkg::TABLE_DEPTH];
   rqt_pkg::cell_ctrl_type cell_ctrl [rqt_pkg::TABLE_DEPTH];
   rqt_pkg::entry_type     nbr [rqt_pkg::TABLE_DEPTH];

   assign head_entry = cells[0];

   for (genvar i = 0; i < rqt_pkg::TABLE_DEPTH; i++) begin : g_cell
      // neighbour towards the tail; the last cell sees the head
      if (i == rqt_pkg::TABLE_DEPTH - 1) begin : g_last
         assign nbr[i] = cells[0];
      end else begin : g_mid
         assign nbr[i] = cells[i+1];
      end

      // per-cell select: insert at tail, else shift with head placement
      always_comb begin
         cell_ctrl[i].load = 1'b0;
         cell_ctrl[i].src  = rqt_pkg::SRC_NBR;
         if (ctrl.ins_en && ctrl.ins_index == rqt_pkg::IDX_W'(i)) begin
            cell_ctrl[i].load = 1'b1;
            cell_ctrl[i].src  = rqt_pkg::SRC_INS;
         end else if (ctrl.step) begin
            cell_ctrl[i].load = 1'b1;
            if (ctrl.place_en && ctrl.place_index == rqt_pkg::IDX_W'(i)) begin
               cell_ctrl[i].src = rqt_pkg::SRC_HEAD;
            end
         end
      end

      rqt_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .nbr_entry  (nbr[i]),
         .head_entry (cells[0]),
         .ins_entry  (ins_entry),
         .cell_entry (cells[i])
      );
   end

endmodule

@@ design/rqt_checker.sv @@
module rqt_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rqt_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // a dropped insert is only reported on a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == rqt_pkg::ST_FULL |->
      rsp_payload.pending_count == rqt_pkg::COUNT_W'(rqt_pkg::TABLE_DEPTH))
      else $error("full status with table not full");

   // empty status means nothing held and no time reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == rqt_pkg::ST_EMPTY |->
      rsp_payload.pending_count == '0 && rsp_payload.oldest_time == '0)
      else $error("empty status with entries held");

   // a failed remove reports no bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == rqt_pkg::ST_NOT_FOUND |->
      rsp_payload.removed_bytes == '0)
      else $error("not found status with removed bytes");

   // the entry count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      rsp_payload.pending_count <= rqt_pkg::COUNT_W'(rqt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind retransmit_queue_table_top rqt_checker u_rqt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
